[sv/qes_pkg.sv]
package qes_pkg;

    // Width of each root on the result stream, signed fixed point
    localparam int ROOT_BITS = 34;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_ONE   = 3'd1,
        ST_TWO   = 3'd2,
        ST_INF   = 3'd3,
        ST_NOSOL = 3'd4
    } t_status;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_ctl;

endpackage

[sv/quadratic_equation_solver.sv]
// Pipeline from request to result: one product stage, one discriminant stage,
//   COEF_BITS+FRAC_BITS+1 square-root cells, one numerator stage,
//   COEF_BITS+FRAC_BITS+2 divider cells and the output register.
// Throughput: one request per cycle unless the output buffer is full.
// A two-entry output buffer takes one more result in while a result waits downstream.
// Reset: synchronous, active low; clears all valid flags, payload registers keep junk.
module quadratic_equation_solver #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // coef_a, coef_b, coef_c from bit 0 up, zero fill to whole bytes
    input  logic [((3*COEF_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // root_status, root_one, root_two from bit 0 up, zero fill to whole bytes
    output logic [((3+2*qes_pkg::ROOT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CB   = COEF_BITS;
    localparam int RB   = qes_pkg::ROOT_BITS;
    localparam int DW   = 2*CB + 2;            // discriminant width
    localparam int SQW  = CB + 1 + FRAC_BITS;  // root digits
    localparam int XW   = 2*SQW;               // radicand width
    localparam int NW   = CB + FRAC_BITS + 3;  // signed numerator width
    localparam int MW   = NW - 1;              // numerator magnitude width
    localparam int DNW  = CB + 1;              // signed divisor width
    localparam int SPW  = NW + DNW;            // payload through the root cells
    localparam int SW   = (MW + 1 > RB) ? MW + 1 : RB;
    localparam int OW   = ((3 + 2*RB + 7)/8)*8;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (RB-1)) - 64'd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    // Whole pipeline advances together; halt only when the output buffer is full.
    logic w_en;
    logic r_skid_valid;
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // ---------------- Stage 1: magnitudes and products ----------------
    logic signed [CB-1:0] w_a, w_b, w_c;
    logic [CB-1:0]        w_ma, w_mb, w_mc;

    assign w_a = s_axis_tdata[CB-1:0];
    assign w_b = s_axis_tdata[2*CB-1:CB];
    assign w_c = s_axis_tdata[3*CB-1:2*CB];

    always_comb begin
        w_ma = w_a[CB-1] ? (~w_a + CB'(1)) : w_a;
        w_mb = w_b[CB-1] ? (~w_b + CB'(1)) : w_b;
        w_mc = w_c[CB-1] ? (~w_c + CB'(1)) : w_c;
    end

    logic                  r1_valid;
    logic signed [CB-1:0]  r1_a, r1_b, r1_c;
    logic [2*CB-1:0]       r1_b2, r1_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a  <= w_a;
            r1_b  <= w_b;
            r1_c  <= w_c;
            r1_b2 <= w_mb * w_mb;
            r1_ac <= w_ma * w_mc;
        end
    end

    // ---------------- Stage 2: discriminant and classification ----------------
    logic [DW-1:0]          w_b2e, w_q4, w_dsum, w_ddif, w_disc;
    logic                   w_acneg, w_dneg;
    logic signed [NW-1:0]   w_bx, w_cx, w_num;
    logic signed [DNW-1:0]  w_den;
    qes_pkg::t_status       w_st;
    logic                   w_quad;

    always_comb begin
        w_b2e   = {2'b00, r1_b2};
        w_q4    = {r1_ac, 2'b00};
        w_dsum  = w_b2e + w_q4;
        w_ddif  = w_b2e - w_q4;
        w_acneg = (r1_a[CB-1] != r1_c[CB-1]);
        w_dneg  = !w_acneg && (w_q4 > w_b2e);
        w_disc  = w_acneg ? w_dsum : w_ddif;
        w_bx    = {{(NW-CB){r1_b[CB-1]}}, r1_b};
        w_cx    = {{(NW-CB){r1_c[CB-1]}}, r1_c};
        w_quad  = 1'b0;
        w_num   = -(w_bx <<< FRAC_BITS);
        w_den   = {r1_a, 1'b0};
        if (r1_a == '0 && r1_b == '0 && r1_c == '0) begin
            w_st = qes_pkg::ST_INF;
        end else if (r1_a == '0 && r1_b == '0) begin
            w_st = qes_pkg::ST_NOSOL;
        end else if (r1_a == '0) begin
            // linear equation: -c / b
            w_st  = qes_pkg::ST_ONE;
            w_num = -(w_cx <<< FRAC_BITS);
            w_den = {r1_b[CB-1], r1_b};
        end else if (w_dneg) begin
            w_st = qes_pkg::ST_NONE;
        end else if (w_disc == '0) begin
            w_st = qes_pkg::ST_ONE;
        end else begin
            w_st   = qes_pkg::ST_TWO;
            w_quad = 1'b1;
        end
    end

    qes_pkg::t_ctl          r2_ctl;
    logic [XW-1:0]          r2_x;
    logic [SPW-1:0]         r2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (w_en) begin
            r2_ctl.valid  <= r1_valid;
            r2_ctl.status <= w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // radicand is D scaled by 2^(2F); zero where no root is taken
            r2_x   <= w_quad ? ({w_disc, {(XW-DW){1'b0}}}) : '0;
            r2_pay <= {w_num, w_den};
        end
    end

    // ---------------- Square-root chain ----------------
    qes_pkg::t_ctl   sq_ctl  [0:SQW];
    logic [XW-1:0]   sq_x    [0:SQW];
    logic [SQW+1:0]  sq_rem  [0:SQW];
    logic [SQW-1:0]  sq_root [0:SQW];
    logic [SPW-1:0]  sq_pay  [0:SQW];

    assign sq_ctl[0]  = r2_ctl;
    assign sq_x[0]    = r2_x;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pay[0]  = r2_pay;

    for (genvar g = 0; g < SQW; g++) begin : g_sqrt
        qes_sqrt_cell #(.XW(XW), .QW(SQW), .PW(SPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (sq_ctl[g]),
            .i_x     (sq_x[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_pay   (sq_pay[g]),
            .o_ctl   (sq_ctl[g+1]),
            .o_x     (sq_x[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_pay   (sq_pay[g+1])
        );
    end

    // ---------------- Stage 3: numerators, magnitudes, signs ----------------
    logic signed [NW-1:0]   w_nb, w_s, w_n1, w_n2, w_a1, w_a2;
    logic signed [DNW-1:0]  w_dv, w_dabs;

    always_comb begin
        w_nb   = sq_pay[SQW][SPW-1:DNW];
        w_dv   = sq_pay[SQW][DNW-1:0];
        w_s    = {{(NW-SQW){1'b0}}, sq_root[SQW]};
        w_n1   = w_nb + w_s;
        w_n2   = w_nb - w_s;
        w_a1   = w_n1[NW-1] ? -w_n1 : w_n1;
        w_a2   = w_n2[NW-1] ? -w_n2 : w_n2;
        w_dabs = w_dv[DNW-1] ? -w_dv : w_dv;
    end

    qes_pkg::t_ctl   r3_ctl;
    logic [MW-1:0]   r3_n1, r3_n2;
    logic [DNW-1:0]  r3_den;
    logic [1:0]      r3_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (w_en) begin
            r3_ctl <= sq_ctl[SQW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_n1  <= w_a1[MW-1:0];
            r3_n2  <= w_a2[MW-1:0];
            r3_den <= w_dabs;
            r3_neg <= {w_n2[NW-1] ^ w_dv[DNW-1], w_n1[NW-1] ^ w_dv[DNW-1]};
        end
    end

    // ---------------- Divider chain ----------------
    qes_pkg::t_ctl   dv_ctl [0:MW];
    logic [DNW-1:0]  dv_den [0:MW];
    logic [MW-1:0]   dv_n1  [0:MW];
    logic [MW-1:0]   dv_n2  [0:MW];
    logic [DNW-1:0]  dv_r1  [0:MW];
    logic [DNW-1:0]  dv_r2  [0:MW];
    logic [1:0]      dv_pay [0:MW];

    assign dv_ctl[0] = r3_ctl;
    assign dv_den[0] = r3_den;
    assign dv_n1[0]  = r3_n1;
    assign dv_n2[0]  = r3_n2;
    assign dv_r1[0]  = '0;
    assign dv_r2[0]  = '0;
    assign dv_pay[0] = r3_neg;

    for (genvar g = 0; g < MW; g++) begin : g_div
        qes_div_cell #(.DW(DNW), .MW(MW), .PW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (dv_ctl[g]),
            .i_den   (dv_den[g]),
            .i_n1    (dv_n1[g]),
            .i_n2    (dv_n2[g]),
            .i_r1    (dv_r1[g]),
            .i_r2    (dv_r2[g]),
            .i_pay   (dv_pay[g]),
            .o_ctl   (dv_ctl[g+1]),
            .o_den   (dv_den[g+1]),
            .o_n1    (dv_n1[g+1]),
            .o_n2    (dv_n2[g+1]),
            .o_r1    (dv_r1[g+1]),
            .o_r2    (dv_r2[g+1]),
            .o_pay   (dv_pay[g+1])
        );
    end

    // ---------------- Sign, saturate, drop unused roots ----------------
    logic signed [SW-1:0]  w_v1, w_v2;
    logic [RB-1:0]         w_r1, w_r2;
    qes_pkg::t_status      w_fst;

    always_comb begin
        w_fst = dv_ctl[MW].status;
        w_v1  = {{(SW-MW){1'b0}}, dv_n1[MW]};
        w_v2  = {{(SW-MW){1'b0}}, dv_n2[MW]};
        if (dv_pay[MW][0]) w_v1 = -w_v1;
        if (dv_pay[MW][1]) w_v2 = -w_v2;
        if (w_v1 > SAT_HI) w_v1 = SAT_HI;
        if (w_v1 < SAT_LO) w_v1 = SAT_LO;
        if (w_v2 > SAT_HI) w_v2 = SAT_HI;
        if (w_v2 < SAT_LO) w_v2 = SAT_LO;
        w_r1 = (w_fst == qes_pkg::ST_ONE || w_fst == qes_pkg::ST_TWO) ? w_v1[RB-1:0] : '0;
        w_r2 = (w_fst == qes_pkg::ST_TWO) ? w_v2[RB-1:0] : '0;
    end

    // ---------------- Output register and skid entry ----------------
    logic                 w_push;
    logic                 r_out_valid;
    qes_pkg::t_status     r_out_st, r_skid_st;
    logic [RB-1:0]        r_out_r1, r_out_r2, r_skid_r1, r_skid_r2;

    assign w_push = w_en && dv_ctl[MW].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            // hold the new result beside the waiting one
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_st <= r_skid_st;
                r_out_r1 <= r_skid_r1;
                r_out_r2 <= r_skid_r2;
            end else begin
                r_out_st <= w_fst;
                r_out_r1 <= w_r1;
                r_out_r2 <= w_r2;
            end
        end else if (w_push) begin
            r_skid_st <= w_fst;
            r_skid_r1 <= w_r1;
            r_skid_r2 <= w_r2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OW-3-2*RB){1'b0}}, r_out_r2, r_out_r1, r_out_st};

    // ---------------- Assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a waiting result");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !s_axis_tready)
        else $error("request taken while output buffer full");

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st == qes_pkg::ST_NONE || r_out_st == qes_pkg::ST_INF
            || r_out_st == qes_pkg::ST_NOSOL)) |-> (r_out_r1 == '0 && r_out_r2 == '0))
        else $error("root present for rootless status");

    a_one_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st == qes_pkg::ST_ONE) |-> (r_out_r2 == '0))
        else $error("second root present for single-root status");

    a_drain_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

endmodule

[sv/qes_sqrt_cell.sv]
// One digit of the restoring square root: take the next radicand pair,
// try the trial subtrahend, shift one root bit in.
module qes_sqrt_cell #(
    parameter int XW = 4,
    parameter int QW = 2,
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qes_pkg::t_ctl      i_ctl,
    input  logic [XW-1:0]      i_x,
    input  logic [QW+1:0]      i_rem,
    input  logic [QW-1:0]      i_root,
    input  logic [PW-1:0]      i_pay,
    output qes_pkg::t_ctl      o_ctl,
    output logic [XW-1:0]      o_x,
    output logic [QW+1:0]      o_rem,
    output logic [QW-1:0]      o_root,
    output logic [PW-1:0]      o_pay
);

    qes_pkg::t_ctl   r_ctl;
    logic [XW-1:0]   r_x;
    logic [QW+1:0]   r_rem;
    logic [QW-1:0]   r_root;
    logic [PW-1:0]   r_pay;

    logic [QW+3:0]   w_shift;
    logic [QW+3:0]   w_trial;
    logic [QW+3:0]   w_diff;
    logic [QW+1:0]   n_rem;
    logic [QW-1:0]   n_root;

    always_comb begin
        w_shift = {i_rem, i_x[XW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_shift - w_trial;
        if (w_shift >= w_trial) begin
            n_rem  = w_diff[QW+1:0];
            n_root = {i_root[QW-2:0], 1'b1};
        end else begin
            n_rem  = w_shift[QW+1:0];
            n_root = {i_root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= {i_x[XW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pay  <= i_pay;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pay  = r_pay;

endmodule

[sv/qes_div_cell.sv]
// One quotient bit of two restoring divisions that share a divisor.
// Each numerator register shifts its next bit out at the top and takes
// the new quotient bit in at the bottom.
module qes_div_cell #(
    parameter int DW = 2,
    parameter int MW = 2,
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qes_pkg::t_ctl      i_ctl,
    input  logic [DW-1:0]      i_den,
    input  logic [MW-1:0]      i_n1,
    input  logic [MW-1:0]      i_n2,
    input  logic [DW-1:0]      i_r1,
    input  logic [DW-1:0]      i_r2,
    input  logic [PW-1:0]      i_pay,
    output qes_pkg::t_ctl      o_ctl,
    output logic [DW-1:0]      o_den,
    output logic [MW-1:0]      o_n1,
    output logic [MW-1:0]      o_n2,
    output logic [DW-1:0]      o_r1,
    output logic [DW-1:0]      o_r2,
    output logic [PW-1:0]      o_pay
);

    qes_pkg::t_ctl   r_ctl;
    logic [DW-1:0]   r_den;
    logic [MW-1:0]   r_n1;
    logic [MW-1:0]   r_n2;
    logic [DW-1:0]   r_r1;
    logic [DW-1:0]   r_r2;
    logic [PW-1:0]   r_pay;

    logic [DW:0]     w_s1;
    logic [DW:0]     w_s2;
    logic [DW:0]     w_d1;
    logic [DW:0]     w_d2;
    logic            w_q1;
    logic            w_q2;

    always_comb begin
        w_s1 = {i_r1, i_n1[MW-1]};
        w_s2 = {i_r2, i_n2[MW-1]};
        w_d1 = w_s1 - {1'b0, i_den};
        w_d2 = w_s2 - {1'b0, i_den};
        w_q1 = (w_s1 >= {1'b0, i_den});
        w_q2 = (w_s2 >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_n1  <= {i_n1[MW-2:0], w_q1};
            r_n2  <= {i_n2[MW-2:0], w_q2};
            r_r1  <= w_q1 ? w_d1[DW-1:0] : w_s1[DW-1:0];
            r_r2  <= w_q2 ? w_d2[DW-1:0] : w_s2[DW-1:0];
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_n1  = r_n1;
    assign o_n2  = r_n2;
    assign o_r1  = r_r1;
    assign o_r2  = r_r2;
    assign o_pay = r_pay;

endmodule

[dv/quadratic_equation_solver_tb.sv]
module quadratic_equation_solver_tb;

    localparam int CB       = 16;
    localparam int FB       = 16;
    localparam int RB       = qes_pkg::ROOT_BITS;
    localparam int IN_W     = ((3*CB+7)/8)*8;
    localparam int OUT_W    = ((3+2*RB+7)/8)*8;
    localparam int LATENCY  = 2*CB + 2*FB + 7;
    localparam int WDOG_MAX = 20000;
    localparam int N_RANDOM = 1800;

    // coef_a sits in the lowest bits, as on the request bus
    typedef struct packed {
        logic signed [CB-1:0] c;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] a;
    } t_coefs;

    typedef struct packed {
        qes_pkg::t_status     status;
        logic signed [RB-1:0] r1;
        logic signed [RB-1:0] r2;
    } t_roots;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    t_coefs pending_q[$];
    t_roots roots_q[$];
    int     n_errors;
    int     idle_cycles;
    bit     stim_done;
    bit     s_accept_seen;

    quadratic_equation_solver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Saturate to the root range
    function automatic logic signed [RB-1:0] clamp_root(input longint v);
        longint hi;
        hi = (longint'(1) <<< (RB-1)) - 1;
        if (v > hi) return hi[RB-1:0];
        if (v < -hi-1) return RB'(-hi-1);
        return v[RB-1:0];
    endfunction

    // Floored square root of d scaled by 2^(2*FB), bit by bit
    function automatic longint isqrt_scaled(input logic [127:0] d);
        logic [127:0] x, root, rem, trial;
        x = d << (2*FB);
        root = '0;
        rem  = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((x >> (2*i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root[63:0]);
    endfunction

    function automatic t_roots solve_quadratic(input t_coefs q);
        t_roots          r;
        longint          a, b, c, nb, den, s;
        logic signed [127:0] disc;
        a = q.a; b = q.b; c = q.c;
        r = '{qes_pkg::ST_NONE, '0, '0};
        if (a == 0 && b == 0) begin
            r.status = (c == 0) ? qes_pkg::ST_INF : qes_pkg::ST_NOSOL;
        end else if (a == 0) begin
            r.status = qes_pkg::ST_ONE;
            r.r1 = clamp_root((-c * (longint'(1) <<< FB)) / b);
        end else begin
            disc = 128'(b*b) - 128'(4*a*c);
            nb   = -b * (longint'(1) <<< FB);
            den  = 2*a;
            if (disc < 0) begin
                r.status = qes_pkg::ST_NONE;
            end else if (disc == 0) begin
                r.status = qes_pkg::ST_ONE;
                r.r1 = clamp_root(nb / den);
            end else begin
                s = isqrt_scaled(disc);
                r.status = qes_pkg::ST_TWO;
                r.r1 = clamp_root((nb + s) / den);
                r.r2 = clamp_root((nb - s) / den);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    function automatic logic [CB-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return CB'($urandom_range(0, 8)) - CB'(4);
            1: return {1'b1, {(CB-1){1'b0}}};
            2: return {1'b0, {(CB-1){1'b1}}};
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic add_request(input int a, input int b, input int c);
        pending_q.push_back(t_coefs'{a: CB'(a), b: CB'(b), c: CB'(c)});
    endtask

    initial begin
        t_coefs q;
        int     r, k;
        // directed: degenerate forms, extremes, each discriminant sign
        add_request(0, 0, 0);
        add_request(0, 0, 5);
        add_request(0, 0, -32768);
        add_request(0, 3, -7);
        add_request(0, -32768, 32767);
        add_request(0, 1, -32768);
        add_request(1, 2, 1);
        add_request(-1, 2, -1);
        add_request(1, 0, -4);
        add_request(1, 0, 4);
        add_request(1, -3, 2);
        add_request(-32768, -32768, -32768);
        add_request(32767, 32767, 32767);
        add_request(-32768, 32767, 32767);
        add_request(1, -32768, -32768);
        add_request(1, 32767, 0);
        add_request(-1, -32768, 32767);
        add_request(3, 5, -2);
        add_request(-32768, 0, 32767);
        add_request(2, 7, 3);
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 9);
            q = '{rand_coef(), rand_coef(), rand_coef()};
            if (r == 0) q.a = '0;
            if (r == 1) begin
                q.a = '0; q.b = '0;
            end
            if (r == 2) begin
                // perfect square: a*(x-k)^2 gives a zero discriminant
                k = $urandom_range(0, 60) - 30;
                q.a = CB'($urandom_range(1, 20));
                q.b = CB'(-2 * k * q.a);
                q.c = CB'(k * k * q.a);
            end
            pending_q.push_back(q);
        end
        stim_done = 1'b1;
    end

    // sender: bursts with random gaps, drive at falling edge
    int gap_left, burst_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_accept_seen)) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                s_tvalid   <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(pending_q.pop_front());
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: its own stall pattern, changed at falling edge
    int stall_mode;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // input monitor: predict on accepted requests
    always @(posedge i_clk) begin
        t_coefs q;
        s_accept_seen = 1'b0;
        if (i_rst_n && s_tvalid && s_tready) begin
            q = t_coefs'(s_tdata[3*CB-1:0]);
            roots_q.push_back(solve_quadratic(q));
            s_accept_seen = 1'b1;
        end
    end

    // output monitor and watchdog
    always @(posedge i_clk) begin
        t_roots got, want;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.status = qes_pkg::t_status'(m_tdata[2:0]);
                got.r1     = m_tdata[3+RB-1:3];
                got.r2     = m_tdata[3+2*RB-1:3+RB];
                if (roots_q.size() == 0) begin
                    report_mismatch("unexpected result status", got.status, -1);
                end else begin
                    want = roots_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("root_status", got.status, want.status);
                    if (got.r1 != want.r1) report_mismatch("root_one", got.r1, want.r1);
                    if (got.r2 != want.r2) report_mismatch("root_two", got.r2, want.r2);
                end
            end
        end
    end

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        gap_left    = 0;
        burst_left  = 0;
        stall_mode  = 0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // hold until stimulus drained and all results seen, or stall too long
        while (!(stim_done && pending_q.size() == 0 && !s_tvalid && roots_q.size() == 0)
               && idle_cycles < WDOG_MAX)
            @(posedge i_clk);
        if (idle_cycles >= WDOG_MAX) begin
            $display("** quadratic_equation_solver: FAILED **");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (n_errors == 0 && roots_q.size() == 0)
                $display("** quadratic_equation_solver: PASSED **");
            else
                $display("** quadratic_equation_solver: FAILED **");
            $finish;
        end
    end

endmodule
